>>> src/sbo_pkg.sv
package sbo_pkg;

   localparam int COORD_BITS     = 24;
   localparam int HALF_BITS      = COORD_BITS - 1;
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int OFS_BITS       = COORD_BITS + 2;
   localparam int MAG_BITS       = COORD_BITS;
   localparam int PROD_BITS      = DIFF_BITS + OFS_BITS;
   localparam int BPROD_BITS     = 2 * COORD_BITS;
   localparam int AXES           = 3;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z,
      CSR_HALF_X,
      CSR_HALF_Y,
      CSR_HALF_Z
   } csr_index_type;

   typedef struct packed {
      logic [AXES-1:0][COORD_BITS-1:0] center;
      logic [AXES-1:0][HALF_BITS-1:0]  half;
   } box_type;

   typedef struct packed {
      logic [AXES-1:0][COORD_BITS-1:0] start;
      logic [AXES-1:0][COORD_BITS-1:0] stop;
   } seg_type;

   typedef struct packed {
      logic [AXES-1:0][DIFF_BITS-1:0] w;
      logic [AXES-1:0][OFS_BITS-1:0]  d;
   } diff_type;

   typedef struct packed {
      logic [AXES-1:0][DIFF_BITS-1:0] w;
      logic [AXES-1:0][OFS_BITS-1:0]  d;
      logic [AXES-1:0][MAG_BITS-1:0]  aw;
      logic                           sep;
   } face_type;

   typedef struct packed {
      logic [AXES-1:0][PROD_BITS-1:0]  pa;
      logic [AXES-1:0][PROD_BITS-1:0]  pb;
      logic [AXES-1:0][BPROD_BITS-1:0] ba;
      logic [AXES-1:0][BPROD_BITS-1:0] bb;
      logic                            sep;
   } prod_type;

endpackage

>>> src/sbo_prep.sv
module sbo_prep (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sbo_pkg::seg_type in_seg,
   input  sbo_pkg::box_type box,
   output logic             out_valid,
   input  logic             out_ready,
   output sbo_pkg::diff_type out_diff
);

   localparam int EXT = sbo_pkg::OFS_BITS - sbo_pkg::COORD_BITS;

   logic              valid_ff;
   logic              valid_in;
   sbo_pkg::diff_type diff_ff;
   sbo_pkg::diff_type diff_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_diff  = diff_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_comb begin
      logic signed [sbo_pkg::OFS_BITS-1:0] s_v;
      logic signed [sbo_pkg::OFS_BITS-1:0] e_v;
      logic signed [sbo_pkg::OFS_BITS-1:0] c_v;
      logic signed [sbo_pkg::OFS_BITS-1:0] w_v;
      diff_in = diff_ff;
      for (int k = 0; k < sbo_pkg::AXES; k++) begin
         s_v = {{EXT{in_seg.start[k][sbo_pkg::COORD_BITS-1]}}, in_seg.start[k]};
         e_v = {{EXT{in_seg.stop[k][sbo_pkg::COORD_BITS-1]}}, in_seg.stop[k]};
         c_v = {{EXT{box.center[k][sbo_pkg::COORD_BITS-1]}}, box.center[k]};
         w_v = e_v - s_v;
         diff_in.w[k] = w_v[sbo_pkg::DIFF_BITS-1:0];
         diff_in.d[k] = s_v + e_v - (c_v <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         diff_ff <= diff_in;
      end
   end

endmodule

>>> src/sbo_face.sv
module sbo_face (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sbo_pkg::diff_type in_diff,
   input  sbo_pkg::box_type  box,
   output logic              out_valid,
   input  logic              out_ready,
   output sbo_pkg::face_type out_face
);

   logic              valid_ff;
   logic              valid_in;
   sbo_pkg::face_type face_ff;
   sbo_pkg::face_type face_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_face  = face_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_comb begin
      logic [sbo_pkg::OFS_BITS-1:0]  ad;
      logic [sbo_pkg::OFS_BITS-1:0]  bnd;
      logic [sbo_pkg::DIFF_BITS-1:0] nw;
      face_in   = face_ff;
      face_in.w = in_diff.w;
      face_in.d = in_diff.d;
      face_in.sep = 1'b0;
      for (int k = 0; k < sbo_pkg::AXES; k++) begin
         ad = in_diff.d[k][sbo_pkg::OFS_BITS-1] ? (~in_diff.d[k] + 1'b1) : in_diff.d[k];
         nw = in_diff.w[k][sbo_pkg::DIFF_BITS-1] ? (~in_diff.w[k] + 1'b1) : in_diff.w[k];
         face_in.aw[k] = nw[sbo_pkg::MAG_BITS-1:0];
         bnd = sbo_pkg::OFS_BITS'({box.half[k], 1'b0}) +
               sbo_pkg::OFS_BITS'(nw[sbo_pkg::MAG_BITS-1:0]);
         if (ad > bnd) begin
            face_in.sep = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         face_ff <= face_in;
      end
   end

endmodule

>>> src/sbo_mult.sv
module sbo_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sbo_pkg::face_type in_face,
   input  sbo_pkg::box_type  box,
   output logic              out_valid,
   input  logic              out_ready,
   output sbo_pkg::prod_type out_prod
);

   logic              valid_ff;
   logic              valid_in;
   sbo_pkg::prod_type prod_ff;
   sbo_pkg::prod_type prod_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   assign prod_in.sep = in_face.sep;

   for (genvar k = 0; k < sbo_pkg::AXES; k++) begin : g_axis
      localparam int I = (k + 1) % sbo_pkg::AXES;
      localparam int J = (k + 2) % sbo_pkg::AXES;
      assign prod_in.pa[k] = $signed(in_face.w[I]) * $signed(in_face.d[J]);
      assign prod_in.pb[k] = $signed(in_face.w[J]) * $signed(in_face.d[I]);
      assign prod_in.ba[k] = {box.half[I], 1'b0} * in_face.aw[J];
      assign prod_in.bb[k] = {box.half[J], 1'b0} * in_face.aw[I];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

endmodule

>>> src/sbo_edge.sv
module sbo_edge (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sbo_pkg::prod_type in_prod,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_overlaps
);

   localparam int V_BITS = sbo_pkg::PROD_BITS + 1;
   localparam int B_BITS = sbo_pkg::BPROD_BITS + 1;
   localparam int C_BITS = V_BITS + 1;

   typedef struct packed {
      logic [sbo_pkg::AXES-1:0][V_BITS-1:0] v;
      logic [sbo_pkg::AXES-1:0][B_BITS-1:0] bnd;
      logic                                 sep;
   } sum_type;

   logic    sum_valid_ff;
   logic    sum_valid_in;
   logic    sum_ready;
   sum_type sum_ff;
   sum_type sum_in;
   logic    valid_ff;
   logic    valid_in;
   logic    overlaps_ff;
   logic    overlaps_in;

   assign sum_ready    = !valid_ff || out_ready;
   assign in_ready     = !sum_valid_ff || sum_ready;
   assign out_valid    = valid_ff;
   assign out_overlaps = overlaps_ff;

   always_comb begin
      sum_valid_in = sum_valid_ff;
      if (in_ready) begin
         sum_valid_in = in_valid;
      end
      valid_in = valid_ff;
      if (sum_ready) begin
         valid_in = sum_valid_ff;
      end
   end

   always_comb begin
      sum_in.sep = in_prod.sep;
      for (int k = 0; k < sbo_pkg::AXES; k++) begin
         sum_in.v[k] = {in_prod.pa[k][sbo_pkg::PROD_BITS-1], in_prod.pa[k]} -
                       {in_prod.pb[k][sbo_pkg::PROD_BITS-1], in_prod.pb[k]};
         sum_in.bnd[k] = B_BITS'(in_prod.ba[k]) + B_BITS'(in_prod.bb[k]);
      end
   end

   always_comb begin
      logic signed [C_BITS-1:0] v_x;
      logic signed [C_BITS-1:0] b_x;
      logic signed [C_BITS-1:0] hi;
      logic signed [C_BITS-1:0] lo;
      logic                     sep;
      sep = sum_ff.sep;
      for (int k = 0; k < sbo_pkg::AXES; k++) begin
         v_x = {sum_ff.v[k][V_BITS-1], sum_ff.v[k]};
         b_x = C_BITS'(sum_ff.bnd[k]);
         hi  = v_x - b_x;
         lo  = v_x + b_x;
         if ((!hi[C_BITS-1] && (hi != '0)) || lo[C_BITS-1]) begin
            sep = 1'b1;
         end
      end
      overlaps_in = !sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sum_ff <= sum_in;
      end
      if (sum_ready && sum_valid_ff) begin
         overlaps_ff <= overlaps_in;
      end
   end

endmodule

>>> src/segment_box_overlap_test.sv
// Channel   Direction  Ports                                   Handshake
// req       in         req_start_{x,y,z}, req_end_{x,y,z}      req_valid / req_stall
// rsp       out        rsp_overlaps                            rsp_valid / rsp_stall
// csr       in         csr_index, csr_wdata                    csr_wr_en, no wait
//
// One transaction enters per cycle while req_stall is low; its flag leaves from the last stage.
// Five register stages: offsets, face tests, cross products, sums, edge compare.
// Stages advance independently; a stage holds while its successor is full and stalled.
// req_stall is low whenever the pipeline has a free stage; rsp_stall never drops data.
// Reset clears the box registers to zero and empties the pipeline.
module segment_box_overlap_test (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sbo_pkg::COORD_BITS-1:0]  req_start_x,
   input  logic signed [sbo_pkg::COORD_BITS-1:0]  req_start_y,
   input  logic signed [sbo_pkg::COORD_BITS-1:0]  req_start_z,
   input  logic signed [sbo_pkg::COORD_BITS-1:0]  req_end_x,
   input  logic signed [sbo_pkg::COORD_BITS-1:0]  req_end_y,
   input  logic signed [sbo_pkg::COORD_BITS-1:0]  req_end_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_overlaps,
   input  logic                                   csr_wr_en,
   input  logic [sbo_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sbo_pkg::COORD_BITS-1:0]         csr_wdata
);

   sbo_pkg::box_type  box_ff;
   sbo_pkg::box_type  box_in;
   sbo_pkg::seg_type  seg;
   sbo_pkg::diff_type diff;
   sbo_pkg::face_type face;
   sbo_pkg::prod_type prod;
   logic              req_ready;
   logic              diff_valid;
   logic              diff_ready;
   logic              face_valid;
   logic              face_ready;
   logic              prod_valid;
   logic              prod_ready;

   always_comb begin
      box_in = box_ff;
      if (csr_wr_en) begin
         case (sbo_pkg::csr_index_type'(csr_index))
            sbo_pkg::CSR_CENTER_X: box_in.center[0] = csr_wdata;
            sbo_pkg::CSR_CENTER_Y: box_in.center[1] = csr_wdata;
            sbo_pkg::CSR_CENTER_Z: box_in.center[2] = csr_wdata;
            sbo_pkg::CSR_HALF_X:   box_in.half[0] = csr_wdata[sbo_pkg::HALF_BITS-1:0];
            sbo_pkg::CSR_HALF_Y:   box_in.half[1] = csr_wdata[sbo_pkg::HALF_BITS-1:0];
            sbo_pkg::CSR_HALF_Z:   box_in.half[2] = csr_wdata[sbo_pkg::HALF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else begin
         box_ff <= box_in;
      end
   end

   assign seg.start[0] = req_start_x;
   assign seg.start[1] = req_start_y;
   assign seg.start[2] = req_start_z;
   assign seg.stop[0]  = req_end_x;
   assign seg.stop[1]  = req_end_y;
   assign seg.stop[2]  = req_end_z;
   assign req_stall    = !req_ready;

   sbo_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_seg    (seg),
      .box       (box_ff),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_diff  (diff)
   );

   sbo_face u_face (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_diff   (diff),
      .box       (box_ff),
      .out_valid (face_valid),
      .out_ready (face_ready),
      .out_face  (face)
   );

   sbo_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (face_valid),
      .in_ready  (face_ready),
      .in_face   (face),
      .box       (box_ff),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_prod  (prod)
   );

   sbo_edge u_edge (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (prod_valid),
      .in_ready     (prod_ready),
      .in_prod      (prod),
      .out_valid    (rsp_valid),
      .out_ready    (!rsp_stall),
      .out_overlaps (rsp_overlaps)
   );

endmodule

>>> src/sbo_check.sv
module sbo_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_overlaps
);

   a_rsp_valid_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_data_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_overlaps))
      else $error("rsp_overlaps changed while stalled");

   a_no_back_pressure : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req_stall raised with the output free");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid)
      else $error("transaction did not reach the output in five cycles");

endmodule

bind segment_box_overlap_test sbo_check u_check (.*);
